@@ design/ip4cs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the IPv4 / L4 checksum engine.
// No dependencies; compiled first.
package ip4cs_pkg;

  // Packet length limit and TCP option allowance.
  localparam int MAX_PACKET_BYTES     = 65535;
  localparam int MAX_TCP_OPTION_BYTES = 40;

  // Protocol numbers.
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Byte offsets of 16-bit words inside the IP header.
  localparam logic [15:0] OFF_PROTO_WORD = 16'd8;
  localparam logic [15:0] OFF_IP_CHECK   = 16'd10;
  localparam logic [15:0] OFF_ADDR_FIRST = 16'd12;
  localparam logic [15:0] OFF_ADDR_LAST  = 16'd18;

  // Byte offsets of 16-bit words inside the L4 segment.
  localparam logic [6:0] OFF_UDP_LEN   = 7'd4;
  localparam logic [6:0] OFF_UDP_CHECK = 7'd6;
  localparam logic [6:0] OFF_TCP_DOFF  = 7'd12;
  localparam logic [6:0] OFF_TCP_CHECK = 7'd16;

  localparam logic [15:0] SUM_MASK = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT_IP   = 3'd1,
    ST_SHORT_IHL  = 3'd2,
    ST_TCP_SHORT  = 3'd3,
    ST_TCP_DOFF   = 3'd4,
    ST_UDP_SHORT  = 3'd5,
    ST_ICMP_SHORT = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_TCP   = 2'd1,
    KIND_UDP   = 2'd2,
    KIND_ICMP  = 2'd3
  } kind_t;

endpackage

@@ design/ip4cs_in_if.sv @@
`timescale 1ns / 1ps
// Input byte channel of the IPv4 / L4 checksum engine.
// Standalone valid/ready interface; no package dependency.
interface ip4cs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  logic       is_fragment;

  modport source (output valid, data_byte, last, is_fragment, input ready);
  modport sink (input valid, data_byte, last, is_fragment, output ready);
endinterface

@@ design/ip4cs_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the IPv4 / L4 checksum engine.
// Standalone valid/ready interface; no package dependency.
interface ip4cs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] ip_checksum;
  logic [15:0] l4_checksum;
  logic [1:0]  l4_kind;
  logic [2:0]  status;

  modport source (output valid, ip_checksum, l4_checksum, l4_kind, status, input ready);
  modport sink (input valid, ip_checksum, l4_checksum, l4_kind, status, output ready);
endinterface

@@ design/ipv4_l4_checksum_engine_core.sv @@
`timescale 1ns / 1ps
// Top level of the IPv4 / TCP / UDP checksum engine.
// Depends on ip4cs_pkg, ip4cs_in_if and ip4cs_out_if.

// The engine takes an IPv4 packet one byte per transaction in wire order and
// returns one result transaction per packet, after the byte marked last. It
// sustains one byte per clock cycle while the input is not stalled: every
// byte passes through a single accumulate step (pair the byte into a 16-bit
// word, classify its offset and add it into the IP and L4 ones-complement
// sums). When the last byte is taken, the accumulated sums and captured
// header fields are moved into a finish register and the accumulators are
// cleared, so the next packet may start in the very next cycle. The finish
// stage then folds and inverts the sums, runs the length checks and loads
// the result register once that register is empty or being read. The result
// register decouples the output: bytes keep flowing while one result waits
// there, and the input stalls, whatever the byte, only while the finish
// register holds a packet that cannot move on because the result register
// is full and not being read. The IP checksum covers the
// header with its check field skipped; for unfragmented TCP and UDP the L4
// checksum adds the segment (check field skipped) and the pseudo-header. An
// odd final byte is padded with a zero low byte, and bytes past the maximum
// packet length are ignored while last still closes the packet.
module ipv4_l4_checksum_engine_core (
  input  logic clk,
  input  logic rst_n,
  ip4cs_in_if.sink    in_stream,
  ip4cs_out_if.source out_stream
);
  import ip4cs_pkg::*;

  // The IP header has at most 30 words, so its raw sum stays below 2^21.
  localparam int IP_SUM_W = 21;

  typedef struct packed {
    logic [IP_SUM_W-1:0] ip_sum;
    logic [31:0]         l4_sum;
    logic [3:0]          header_words;
    logic [7:0]          protocol_number;
    logic [3:0]          tcp_data_offset;
    logic [15:0]         udp_length;
    logic [15:0]         tcp_check_word;
    logic [15:0]         udp_check_word;
    logic [15:0]         byte_count;
    logic                is_fragment;
  } fin_t;

  // Fold a raw 32-bit sum to 16 bits with end-around carry and invert it.
  function automatic logic [15:0] fold_invert(input logic [31:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, s[31:16]} + {1'b0, s[15:0]};
    s2 = s1 + {16'b0, s1[16]};
    return ~s2[15:0];
  endfunction

  // Accumulator state.
  logic [15:0]         byte_count_r, byte_count_nxt;
  logic [IP_SUM_W-1:0] ip_sum_r, ip_sum_nxt;
  logic [31:0]         l4_sum_r, l4_sum_nxt;
  logic [3:0]          header_words_r, header_words_nxt;
  logic [7:0]          protocol_r, protocol_nxt;
  logic [7:0]          high_byte_r, high_byte_nxt;
  logic [3:0]          tcp_doff_r, tcp_doff_nxt;
  logic [15:0]         udp_len_r, udp_len_nxt;
  logic [15:0]         tcp_chk_r, tcp_chk_nxt;
  logic [15:0]         udp_chk_r, udp_chk_nxt;

  // Finish stage and result register.
  logic  fin_v_r;
  fin_t  fin_r;
  logic  out_valid_r;
  logic [15:0] out_ip_ck_r, out_l4_ck_r;
  kind_t       out_kind_r;
  status_t     out_status_r;

  logic in_fire, fin_adv;

  // Word assembly.
  logic        take_byte, pair_word, tail_word, word_en;
  logic [15:0] word_off, word_val;
  logic [15:0] hl_16;
  logic [6:0]  hl_7;
  logic        in_header, in_segment, in_addr;
  logic [16:0] l4_add;

  // The finish register is free when empty or when its result moves on this
  // cycle; a byte that does not end a packet never needs it, but a single
  // ready keeps the handshake independent of the payload.
  assign fin_adv         = fin_v_r && (!out_valid_r || out_stream.ready);
  assign in_stream.ready = !fin_v_r || fin_adv;
  assign in_fire         = in_stream.valid && in_stream.ready;

  always_comb begin
    take_byte = byte_count_r < 16'(MAX_PACKET_BYTES);

    // Header length is learned from byte 0, possibly in this very cycle.
    header_words_nxt = (take_byte && byte_count_r == 16'd0) ?
                       in_stream.data_byte[3:0] : header_words_r;
    high_byte_nxt    = (take_byte && !byte_count_r[0]) ? in_stream.data_byte : high_byte_r;
    byte_count_nxt   = take_byte ? byte_count_r + 16'd1 : byte_count_r;

    // At most one word completes per byte: either an odd byte closes a pair,
    // or the packet ends on an odd count and the held byte is zero padded.
    pair_word = take_byte && byte_count_r[0];
    tail_word = in_stream.last && byte_count_nxt[0];
    word_en   = pair_word || tail_word;
    word_off  = pair_word ? byte_count_r - 16'd1 : byte_count_nxt - 16'd1;
    word_val  = pair_word ? {high_byte_r, in_stream.data_byte} : {high_byte_nxt, 8'h00};

    hl_7       = {1'b0, header_words_nxt, 2'b00};
    hl_16      = {9'b0, hl_7};
    in_header  = word_off < hl_16;
    in_segment = !in_header;
    in_addr    = word_off >= OFF_ADDR_FIRST && word_off <= OFF_ADDR_LAST;

    ip_sum_nxt = ip_sum_r;
    if (word_en && in_header && word_off != OFF_IP_CHECK) begin
      ip_sum_nxt = ip_sum_r + IP_SUM_W'(word_val);
    end

    // Address words belong to the pseudo-header; with a short IHL they may
    // also fall inside the segment and then count twice.
    l4_add = ((word_en && in_addr) ? {1'b0, word_val} : 17'd0) +
             ((word_en && in_segment) ? {1'b0, word_val} : 17'd0);
    l4_sum_nxt = l4_sum_r + 32'(l4_add);

    protocol_nxt = (word_en && word_off == OFF_PROTO_WORD) ? word_val[7:0] : protocol_r;
    udp_len_nxt  = (word_en && word_off == hl_16 + 16'(OFF_UDP_LEN)) ? word_val : udp_len_r;
    udp_chk_nxt  = (word_en && word_off == hl_16 + 16'(OFF_UDP_CHECK)) ? word_val : udp_chk_r;
    tcp_doff_nxt = (word_en && word_off == hl_16 + 16'(OFF_TCP_DOFF)) ?
                   word_val[15:12] : tcp_doff_r;
    tcp_chk_nxt  = (word_en && word_off == hl_16 + 16'(OFF_TCP_CHECK)) ? word_val : tcp_chk_r;
  end

  // Accumulators: updated per byte, cleared after the last byte of a packet.
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_stream.last)) begin
      byte_count_r   <= '0;
      ip_sum_r       <= '0;
      l4_sum_r       <= '0;
      header_words_r <= '0;
      protocol_r     <= '0;
      high_byte_r    <= '0;
      tcp_doff_r     <= '0;
      udp_len_r      <= '0;
      tcp_chk_r      <= '0;
      udp_chk_r      <= '0;
    end else if (in_fire) begin
      byte_count_r   <= byte_count_nxt;
      ip_sum_r       <= ip_sum_nxt;
      l4_sum_r       <= l4_sum_nxt;
      header_words_r <= header_words_nxt;
      protocol_r     <= protocol_nxt;
      high_byte_r    <= high_byte_nxt;
      tcp_doff_r     <= tcp_doff_nxt;
      udp_len_r      <= udp_len_nxt;
      tcp_chk_r      <= tcp_chk_nxt;
      udp_chk_r      <= udp_chk_nxt;
    end
  end

  // Snapshot of the packet's final state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (in_fire && in_stream.last) begin
      fin_v_r <= 1'b1;
    end else if (fin_adv) begin
      fin_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_stream.last) begin
      fin_r.ip_sum          <= ip_sum_nxt;
      fin_r.l4_sum          <= l4_sum_nxt;
      fin_r.header_words    <= header_words_nxt;
      fin_r.protocol_number <= protocol_nxt;
      fin_r.tcp_data_offset <= tcp_doff_nxt;
      fin_r.udp_length      <= udp_len_nxt;
      fin_r.tcp_check_word  <= tcp_chk_nxt;
      fin_r.udp_check_word  <= udp_chk_nxt;
      fin_r.byte_count      <= byte_count_nxt;
      fin_r.is_fragment     <= in_stream.is_fragment;
    end
  end

  // Finish stage: fold the sums and run the length checks in the order
  // total length, header length, fragment, then the protocol checks.
  logic [16:0] n_17, hl_17, tcp_end_17, udp_end_17;
  logic [6:0]  thl_7;
  logic [15:0] pay_len;
  logic [15:0] chk_word;
  logic [31:0] l4_total;
  logic [15:0] ip_ck_nxt, l4_ck_nxt;
  kind_t       kind_nxt;
  status_t     status_nxt;

  always_comb begin
    n_17       = {1'b0, fin_r.byte_count};
    hl_17      = {11'b0, fin_r.header_words, 2'b00};
    thl_7      = {1'b0, fin_r.tcp_data_offset, 2'b00};
    tcp_end_17 = hl_17 + {10'b0, thl_7};
    udp_end_17 = hl_17 + {1'b0, fin_r.udp_length};
    pay_len    = fin_r.byte_count - hl_17[15:0];
    chk_word   = (fin_r.protocol_number == PROTO_TCP) ?
                 fin_r.tcp_check_word : fin_r.udp_check_word;
    l4_total   = fin_r.l4_sum - {16'b0, chk_word} +
                 {24'b0, fin_r.protocol_number} + {16'b0, pay_len};

    ip_ck_nxt  = fold_invert(32'(fin_r.ip_sum));
    l4_ck_nxt  = 16'h0000;
    kind_nxt   = KIND_OTHER;
    status_nxt = ST_OK;

    priority if (n_17 < 17'd20) begin
      status_nxt = ST_SHORT_IP;
      ip_ck_nxt  = 16'h0000;
    end else if (n_17 < hl_17) begin
      status_nxt = ST_SHORT_IHL;
      ip_ck_nxt  = 16'h0000;
    end else if (!fin_r.is_fragment) begin
      priority if (fin_r.protocol_number == PROTO_TCP) begin
        kind_nxt = KIND_TCP;
        priority if (n_17 < hl_17 + 17'd20 || n_17 < tcp_end_17) begin
          status_nxt = ST_TCP_SHORT;
        end else if (thl_7 < 7'd20 || thl_7 > 7'(20 + MAX_TCP_OPTION_BYTES)) begin
          status_nxt = ST_TCP_DOFF;
        end else begin
          l4_ck_nxt = fold_invert(l4_total) & SUM_MASK;
        end
      end else if (fin_r.protocol_number == PROTO_UDP) begin
        kind_nxt = KIND_UDP;
        priority if (n_17 < hl_17 + 17'd8 || n_17 < udp_end_17) begin
          status_nxt = ST_UDP_SHORT;
        end else begin
          l4_ck_nxt = fold_invert(l4_total) & SUM_MASK;
        end
      end else if (fin_r.protocol_number == PROTO_ICMP) begin
        kind_nxt = KIND_ICMP;
        if (n_17 < hl_17 + 17'd8) begin
          status_nxt = ST_ICMP_SHORT;
        end
      end else begin
        kind_nxt = KIND_OTHER;
      end
    end else begin
      kind_nxt = KIND_OTHER;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv) begin
      out_ip_ck_r  <= ip_ck_nxt;
      out_l4_ck_r  <= l4_ck_nxt;
      out_kind_r   <= kind_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.ip_checksum = out_ip_ck_r;
  assign out_stream.l4_checksum = out_l4_ck_r;
  assign out_stream.l4_kind     = out_kind_r;
  assign out_stream.status      = out_status_r;

  // A packet end always leaves the accumulators cleared for the next packet.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_stream.last |=> byte_count_r == 16'd0 && l4_sum_r == 32'd0)
    else $error("accumulators not cleared after packet end");

  // A finished packet that cannot move on stays in the finish register.
  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r && !fin_adv |=> fin_v_r)
    else $error("finish register dropped a packet");

  // Any failed check, or no TCP/UDP, yields a zero L4 checksum.
  a_l4_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK || out_kind_r == KIND_OTHER ||
                    out_kind_r == KIND_ICMP) |-> out_l4_ck_r == 16'h0000)
    else $error("nonzero L4 checksum with no valid segment");

  // Too-short packets report a zero IP checksum and no L4 kind.
  a_ip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_SHORT_IP || out_status_r == ST_SHORT_IHL)
    |-> out_ip_ck_r == 16'h0000 && out_kind_r == KIND_OTHER)
    else $error("short packet with IP checksum or L4 kind");

endmodule
